// ===== design/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define RLC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RLC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/rlc_pkg.sv =====
package rlc_pkg;

	localparam int RLC_MAX_CELLS = 64;
	localparam int RLC_PW = 21;
	localparam int RLC_CWW = 16;

	// one queued cell word
	typedef struct packed {
		logic signed [RLC_PW-1:0] global_x;
		logic [RLC_CWW-1:0] cell_width;
		logic last_cell;
	} cell_t;

	// row configuration seen by the back end
	typedef struct packed {
		logic signed [RLC_PW-1:0] row_left;
		logic signed [RLC_PW-1:0] row_right;
		logic signed [RLC_PW-1:0] row_y;
	} row_cfg_t;

endpackage

// ===== design/rlc_ram.sv =====
module rlc_ram #(
	parameter int W = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [W-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0] rdata
);

	logic [W-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/rlc_front.sv =====
module rlc_front import rlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input cell_t in_word,
	output logic q_valid,
	output cell_t q_word,
	input logic q_pop
);

	cell_t buf_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign pop = q_pop && q_valid;
	assign q_valid = (cnt_q != 2'd0);
	assign q_word = buf_q[rd_q];

	// two-word queue between intake and the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// payload storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_word;
		end
	end

endmodule

// ===== design/rlc_div.sv =====
module rlc_div #(
	parameter int QW = 31,
	parameter int MW = 7
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [QW-1:0] dividend,
	input logic [MW-1:0] divisor,
	output logic done,
	output logic signed [QW-1:0] quot
);

	localparam int CNTW = $clog2(QW + 1);

	logic busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [QW-1:0] num_q;
	logic [MW-1:0] rem_q;
	logic [MW-1:0] dv_q;
	logic neg_q;
	logic [MW:0] sh;
	logic ge;
	logic [MW:0] diff;
	logic [QW-1:0] mag_next;

	// one quotient bit per cycle, restoring
	assign sh = {rem_q, num_q[QW-1]};
	assign ge = (sh >= {1'b0, dv_q});
	assign diff = sh - {1'b0, dv_q};
	assign mag_next = {num_q[QW-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNTW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[QW-1] ? (QW'(0) - dividend) : dividend;
			neg_q <= dividend[QW-1];
			rem_q <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			num_q <= mag_next;
			rem_q <= ge ? diff[MW-1:0] : sh[MW-1:0];
			if (cnt_q == CNTW'(1)) begin
				quot <= neg_q ? $signed(QW'(0) - mag_next) : $signed(mag_next);
			end
		end
	end

endmodule

// ===== design/rlc_back.sv =====
module rlc_back import rlc_pkg::*; #(
	parameter int MAX_CELLS = RLC_MAX_CELLS
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input cell_t q_word,
	output logic q_pop,
	input row_cfg_t cfg,
	output logic out_valid,
	input logic out_stall,
	output logic signed [RLC_PW-1:0] legal_x,
	output logic signed [RLC_PW-1:0] legal_y,
	output logic row_failed,
	output logic last_out
);

	localparam int CW = $clog2(MAX_CELLS);
	localparam int NW = CW + 1;
	localparam int TWW = RLC_CWW + CW;
	localparam int QW = TWW + CW + 3;
	localparam int PW = RLC_PW;
	localparam int CMPW = TWW + 2;
	localparam int XW = QW + 1;
	localparam int RECW = PW + NW + QW + TWW + CW;
	localparam int PRW = NW + TWW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV = 4'd1;
	localparam logic [3:0] ST_DIVW = 4'd2;
	localparam logic [3:0] ST_ECL = 4'd3;
	localparam logic [3:0] ST_ECL2 = 4'd4;
	localparam logic [3:0] ST_EW = 4'd5;
	localparam logic [3:0] ST_EOUT = 4'd6;

	logic [3:0] state_q;

	// top cluster lives in registers, the rest in the cluster memory
	logic signed [PW-1:0] t_pos_q;
	logic [NW-1:0] t_m_q;
	logic signed [QW-1:0] t_q_q;
	logic [TWW-1:0] t_tw_q;
	logic [CW-1:0] t_first_q;
	logic [NW-1:0] depth_q;
	logic [NW-1:0] loaded_q;
	logic fail_q;
	logic last_q;
	logic [PRW-1:0] prod_q;

	// emission walk
	logic [NW-1:0] e_q;
	logic [NW-1:0] c_q;
	logic [NW-1:0] r_q;
	logic [PW-1:0] x_q;

	// memories
	logic cl_we;
	logic [CW-1:0] cl_waddr;
	logic [RECW-1:0] cl_wdata;
	logic cl_re;
	logic [CW-1:0] cl_raddr;
	logic [RECW-1:0] cl_rdata;
	logic wd_we;
	logic wd_re;
	logic [RLC_CWW-1:0] wd_rdata;

	// divider
	logic div_start;
	logic div_done;
	logic signed [QW-1:0] div_quot;

	// fields of the cluster read back
	logic signed [PW-1:0] b_pos;
	logic [NW-1:0] b_m;
	logic signed [QW-1:0] b_q;
	logic [TWW-1:0] b_tw;
	logic [CW-1:0] b_first;

	logic signed [CMPW-1:0] top_end;
	logic signed [CMPW-1:0] gx_c;
	logic new_cl;
	logic full;
	logic signed [CMPW-1:0] span;
	logic too_wide;
	logic signed [XW-1:0] qx;
	logic signed [XW-1:0] lim_hi;
	logic signed [XW-1:0] rl_x;
	logic signed [XW-1:0] xc_x;
	logic signed [PW-1:0] xc;
	logic signed [PW-1:0] sat_x;
	logic signed [CMPW-1:0] below_end;
	logic no_merge;
	logic slot_free;
	logic emit;

	assign b_first = cl_rdata[CW-1:0];
	assign b_tw = cl_rdata[CW +: TWW];
	assign b_q = $signed(cl_rdata[CW+TWW +: QW]);
	assign b_m = cl_rdata[CW+TWW+QW +: NW];
	assign b_pos = $signed(cl_rdata[CW+TWW+QW+NW +: PW]);

	// classification of the incoming cell against the top cluster
	assign full = (loaded_q >= NW'(MAX_CELLS));
	assign top_end = $signed({{(CMPW-PW){t_pos_q[PW-1]}}, t_pos_q}) + $signed({2'b00, t_tw_q});
	assign gx_c = $signed({{(CMPW-PW){q_word.global_x[PW-1]}}, q_word.global_x});
	assign new_cl = (depth_q == '0) || (top_end <= gx_c);

	// memory port control
	assign cl_we = (state_q == ST_IDLE) && q_valid && !full && new_cl && (depth_q != '0);
	assign cl_waddr = CW'(depth_q - 1'b1);
	assign cl_wdata = {t_pos_q, t_m_q, t_q_q, t_tw_q, t_first_q};
	assign cl_re = (state_q == ST_DIV) || (state_q == ST_ECL);
	assign cl_raddr = (state_q == ST_DIV) ? CW'(depth_q - NW'(2)) : CW'(c_q);
	assign wd_we = (state_q == ST_IDLE) && q_valid && !full;
	assign wd_re = (state_q == ST_EW);
	assign q_pop = (state_q == ST_IDLE);
	assign div_start = (state_q == ST_DIV);

	// width check, saturation and clamping of the quotient
	assign span = $signed({{(CMPW-PW){cfg.row_right[PW-1]}}, cfg.row_right})
		- $signed({{(CMPW-PW){cfg.row_left[PW-1]}}, cfg.row_left});
	assign too_wide = $signed({2'b00, t_tw_q}) > span;
	assign qx = $signed({div_quot[QW-1], div_quot});
	assign rl_x = $signed({{(XW-PW){cfg.row_left[PW-1]}}, cfg.row_left});
	assign lim_hi = $signed({{(XW-PW){cfg.row_right[PW-1]}}, cfg.row_right})
		- $signed({{(XW-TWW){1'b0}}, t_tw_q});

	always_comb begin
		xc_x = (qx < rl_x) ? rl_x : qx;
		if (xc_x > lim_hi) begin
			xc_x = lim_hi;
		end
		xc = $signed(xc_x[PW-1:0]);
		priority if (qx > $signed(XW'(2 ** (PW - 1) - 1))) begin
			sat_x = $signed({1'b0, {(PW-1){1'b1}}});
		end else if (qx < -$signed(XW'(2 ** (PW - 1)))) begin
			sat_x = $signed({1'b1, {(PW-1){1'b0}}});
		end else begin
			sat_x = $signed(qx[PW-1:0]);
		end
	end

	assign below_end = $signed({{(CMPW-PW){b_pos[PW-1]}}, b_pos}) + $signed({2'b00, b_tw});
	assign no_merge = (depth_q == NW'(1))
		|| (below_end <= $signed({{(CMPW-PW){xc[PW-1]}}, xc}));
	assign slot_free = !out_valid || !out_stall;
	assign emit = (state_q == ST_EOUT) && slot_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			loaded_q <= '0;
			fail_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// output register: load on emit, clear once taken
			if (emit) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						last_q <= q_word.last_cell;
						e_q <= '0;
						c_q <= '0;
						if (full) begin
							fail_q <= 1'b1;
							state_q <= q_word.last_cell ? ST_ECL : ST_IDLE;
						end else begin
							if (new_cl) begin
								t_pos_q <= q_word.global_x;
								t_m_q <= NW'(1);
								t_q_q <= QW'(q_word.global_x);
								t_tw_q <= TWW'(q_word.cell_width);
								t_first_q <= CW'(loaded_q);
								depth_q <= depth_q + 1'b1;
							end else begin
								t_m_q <= t_m_q + 1'b1;
								t_q_q <= t_q_q + QW'(q_word.global_x)
									- $signed({{(QW-TWW){1'b0}}, t_tw_q});
								t_tw_q <= t_tw_q + TWW'(q_word.cell_width);
							end
							loaded_q <= loaded_q + 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					state_q <= ST_DIVW;
				end
				ST_DIVW: begin
					prod_q <= t_m_q * b_tw;
					if (div_done) begin
						if (too_wide) begin
							t_pos_q <= sat_x;
							fail_q <= 1'b1;
							state_q <= last_q ? ST_ECL : ST_IDLE;
						end else if (no_merge) begin
							t_pos_q <= xc;
							state_q <= last_q ? ST_ECL : ST_IDLE;
						end else begin
							// fold the top cluster into the one below
							t_pos_q <= b_pos;
							t_q_q <= b_q + t_q_q - $signed({{(QW-PRW){1'b0}}, prod_q});
							t_m_q <= b_m + t_m_q;
							t_tw_q <= b_tw + t_tw_q;
							t_first_q <= b_first;
							depth_q <= depth_q - 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_ECL: begin
					state_q <= ST_ECL2;
				end
				ST_ECL2: begin
					if (c_q == depth_q - 1'b1) begin
						x_q <= t_pos_q;
						r_q <= t_m_q;
					end else begin
						x_q <= b_pos;
						r_q <= b_m;
					end
					state_q <= ST_EW;
				end
				ST_EW: begin
					state_q <= ST_EOUT;
				end
				ST_EOUT: begin
					if (slot_free) begin
						legal_x <= $signed(x_q);
						legal_y <= cfg.row_y;
						row_failed <= fail_q;
						last_out <= (e_q == loaded_q - 1'b1);
						x_q <= x_q + PW'(wd_rdata);
						e_q <= e_q + 1'b1;
						r_q <= r_q - 1'b1;
						if (e_q == loaded_q - 1'b1) begin
							depth_q <= '0;
							loaded_q <= '0;
							fail_q <= 1'b0;
							state_q <= ST_IDLE;
						end else if (r_q == NW'(1)) begin
							c_q <= c_q + 1'b1;
							state_q <= ST_ECL;
						end else begin
							state_q <= ST_EW;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	rlc_ram #(.W(RECW), .DEPTH(MAX_CELLS)) u_cl_ram (
		.clk(clk),
		.we(cl_we),
		.waddr(cl_waddr),
		.wdata(cl_wdata),
		.re(cl_re),
		.raddr(cl_raddr),
		.rdata(cl_rdata)
	);

	rlc_ram #(.W(RLC_CWW), .DEPTH(MAX_CELLS)) u_wd_ram (
		.clk(clk),
		.we(wd_we),
		.waddr(CW'(loaded_q)),
		.wdata(q_word.cell_width),
		.re(wd_re),
		.raddr(CW'(e_q)),
		.rdata(wd_rdata)
	);

	rlc_div #(.QW(QW), .MW(NW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(t_q_q),
		.divisor(t_m_q),
		.done(div_done),
		.quot(div_quot)
	);

endmodule

// ===== design/row_legalizer_cluster_collapse.sv =====
// Legalizes one placement row Abacus-style with unit cell weights. Cells arrive sorted by
// global x, one word each, and end with a word marked last_cell; after it the block emits one
// result word per stored cell in input order, the final one flagged by last_out. Each cell
// is inserted, then a collapse step runs in which the bit-serial signed divider computes the
// cluster x over QW bits (QW = 16 + 2*log2(MAX_CELLS) + 3, 31 bits at 64 cells); every merge
// into the cluster below repeats that step. Emission reads the cluster memory once per
// cluster and the width memory once per cell through their single read ports. A two-word
// input queue lets cells be taken while the sequencer works. Row registers sit at byte
// addresses 0, 4 and 8 and should be written only while the block is idle.
module row_legalizer_cluster_collapse import rlc_pkg::*; #(
	parameter int MAX_CELLS = RLC_MAX_CELLS
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic in_valid,
	output logic in_stall,
	input logic signed [RLC_PW-1:0] global_x,
	input logic [RLC_CWW-1:0] cell_width,
	input logic last_cell,
	output logic out_valid,
	input logic out_stall,
	output logic signed [RLC_PW-1:0] legal_x,
	output logic signed [RLC_PW-1:0] legal_y,
	output logic row_failed,
	output logic last_out
);

	localparam logic [1:0] REG_LEFT = 2'd0;
	localparam logic [1:0] REG_RIGHT = 2'd1;
	localparam logic [1:0] REG_Y = 2'd2;

	row_cfg_t cfg_q;
	cell_t in_word;
	cell_t q_word;
	logic q_valid;
	logic q_pop;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_left <= '0;
			cfg_q.row_right <= $signed({1'b0, {(RLC_PW-1){1'b1}}});
			cfg_q.row_y <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_LEFT: cfg_q.row_left <= $signed(pwdata[RLC_PW-1:0]);
				REG_RIGHT: cfg_q.row_right <= $signed(pwdata[RLC_PW-1:0]);
				REG_Y: cfg_q.row_y <= $signed(pwdata[RLC_PW-1:0]);
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_LEFT: prdata = {{(32-RLC_PW){cfg_q.row_left[RLC_PW-1]}}, cfg_q.row_left};
			REG_RIGHT: prdata = {{(32-RLC_PW){cfg_q.row_right[RLC_PW-1]}}, cfg_q.row_right};
			REG_Y: prdata = {{(32-RLC_PW){cfg_q.row_y[RLC_PW-1]}}, cfg_q.row_y};
			default: prdata = '0;
		endcase
	end

	assign in_word.global_x = global_x;
	assign in_word.cell_width = cell_width;
	assign in_word.last_cell = last_cell;

	rlc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.q_valid(q_valid),
		.q_word(q_word),
		.q_pop(q_pop)
	);

	rlc_back #(.MAX_CELLS(MAX_CELLS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_word(q_word),
		.q_pop(q_pop),
		.cfg(cfg_q),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.legal_x(legal_x),
		.legal_y(legal_y),
		.row_failed(row_failed),
		.last_out(last_out)
	);

endmodule

// ===== design/rlc_checker.sv =====
`include "assert_macros.svh"

module rlc_checker (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	input logic in_valid,
	input logic in_stall,
	input logic [20:0] global_x,
	input logic [15:0] cell_width,
	input logic last_cell,
	input logic out_valid,
	input logic out_stall,
	input logic [20:0] legal_x,
	input logic [20:0] legal_y,
	input logic row_failed,
	input logic last_out
);

	logic out_wait;
	logic in_wait;
	logic p_access;
	logic [43:0] out_bits;
	logic [37:0] in_bits;
	logic [36:0] p_bits;

	assign out_wait = out_valid && out_stall;
	assign in_wait = in_valid && in_stall;
	assign p_access = psel && penable;
	assign out_bits = {legal_x, legal_y, row_failed, last_out};
	assign in_bits = {global_x, cell_width, last_cell};
	assign p_bits = {pwrite, paddr, pwdata};

	// a stalled result word holds
	`RLC_ASSERT(a_out_hold, clk, arst_n, out_wait |=> out_valid && $stable(out_bits), "result held")

	// a stalled input word holds
	`RLC_ASSERT(a_in_hold, clk, arst_n, in_wait |=> in_valid && $stable(in_bits), "input held")

	// reset empties the queue and the output register
	`RLC_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> !out_valid && !in_stall, "not idle in reset")

	// config access follows a setup cycle with the same address and data
	`RLC_ASSERT(a_apb, clk, arst_n, p_access |-> $past(psel && !penable) && $stable(p_bits), "apb")

	// config port never waits
	`RLC_ASSERT(a_pready, clk, arst_n, pready, "pready low")

endmodule

bind row_legalizer_cluster_collapse rlc_checker u_rlc_checker (.*);
